### design/imu_rsu_pkg.sv
// imu_rsu_pkg: widths, selector codes, register indexes and scaling constants
// for the raw sample to units converter and its checker
// no dependencies

package imu_rsu_pkg;

   localparam int FUNC_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int RAW_W     = 16;
   localparam int SCALE_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W     = 22;

   // sample kinds
   localparam logic [FUNC_W-1:0] FUNC_ACCEL  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GYRO   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEMP   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_SCALE  = 2'd1;

   // datapath widths
   localparam int MAG_W   = 16;           // magnitude, up to 32768
   localparam int COEF_W  = 18;
   localparam int PROD_W  = 33;           // magnitude times coefficient
   localparam int NUM_W   = 32;           // rounded numerator
   localparam int RCP_W   = 22;
   localparam int WIDE_W  = NUM_W + RCP_W;
   localparam int QUO_W   = 21;
   localparam int TQ_W    = 17;           // temperature quotient estimate
   localparam int SHIFT_W = 4;

   localparam int NUM_STAGES = 6;

   // acceleration: raw*980665/(100*S) reduces to raw*196133/(5*2^(k+2)),
   // S = 2^k; shift by k+1, add 5, then divide by ten
   localparam logic [COEF_W-1:0]  ACCEL_COEF       = 18'd196133;
   localparam logic [SHIFT_W-1:0] ACCEL_SHIFT_BASE = 4'd15;
   localparam logic [NUM_W-1:0]   ACCEL_HALF       = 32'd5;
   localparam logic [RCP_W-1:0]   ACCEL_RCP        = 22'd3355444;  // ceil(2^25/10)
   localparam int                 ACCEL_RCP_SHIFT  = 25;

   // angular velocity: raw*15625 / 2^(11-g)
   localparam logic [COEF_W-1:0]  GYRO_COEF       = 18'd15625;
   localparam logic [SHIFT_W-1:0] GYRO_SHIFT_BASE = 4'd11;
   localparam logic [RCP_W-1:0]   GYRO_RCP        = 22'd1;

   // temperature: raw*100000/33387 + 21000
   localparam logic [COEF_W-1:0] TEMP_COEF      = 18'd100000;
   localparam logic [NUM_W-1:0]  TEMP_HALF      = 32'd16693;
   localparam logic [RCP_W-1:0]  TEMP_RCP       = 22'd128641;     // floor(2^32/33387)
   localparam int                TEMP_RCP_SHIFT = 32;
   localparam logic [15:0]       TEMP_DIV       = 16'd33387;
   localparam logic signed [OUT_W-1:0] TEMP_OFFSET = 22'sd21000;

   localparam logic signed [OUT_W-1:0] OUT_MIN = -22'sd2000000;
   localparam logic signed [OUT_W-1:0] OUT_MAX = 22'sd2000000;

   // per-stage control that rides along with the data
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic               neg;
      logic [SCALE_W-1:0] accel_scale;
      logic [SCALE_W-1:0] gyro_scale;
   } ctl_type;

endpackage

### design/imu_raw_sample_to_units.sv
// imu_raw_sample_to_units: six-stage pipeline that turns a big-endian raw
// sensor sample into milli-units; uses imu_rsu_pkg
// throughput: one command per clock while busy is low, set by the six-stage multiply pipeline
// the receiver cannot stall, so the pipeline always advances
// reset (synchronous): clears the valid bits and both scale registers to 0,
//    busy is high for one clock after reset drops
module imu_raw_sample_to_units import imu_rsu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [BYTE_W-1:0]        req_raw_high,
   input  logic [BYTE_W-1:0]        req_raw_low,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_scaled_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SCALE_W-1:0]       csr_wdata
);

   logic [SCALE_W-1:0] accel_scale_ff;
   logic [SCALE_W-1:0] gyro_scale_ff;
   logic               busy_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   ctl_type            ctl_ff [NUM_STAGES-1];
   ctl_type            ctl_in;

   logic [RAW_W-1:0]   raw;
   logic [MAG_W-1:0]   mag_in;
   logic [MAG_W-1:0]   mag_ff;
   logic [COEF_W-1:0]  coef;
   logic [MAG_W+COEF_W-1:0] prod_full;
   logic [PROD_W-1:0]  prod_ff;
   logic [SHIFT_W-1:0] ash;
   logic [SHIFT_W-1:0] gsh;
   logic [PROD_W-1:0]  ghalf;
   logic [NUM_W-1:0]   num_in;
   logic [NUM_W-1:0]   num_ff;
   logic [RCP_W-1:0]   rcp;
   logic [WIDE_W-1:0]  wide_in;
   logic [WIDE_W-1:0]  wide_ff;
   logic [NUM_W-1:0]   num4_ff;
   logic [QUO_W-1:0]   q0_in;
   logic [QUO_W-1:0]   q0_ff;
   logic [TQ_W-1:0]    tq;
   logic [TQ_W+16-1:0] qd_full;
   logic [NUM_W-1:0]   qd_ff;
   logic [NUM_W-1:0]   num5_ff;
   logic [NUM_W-1:0]   rem;
   logic               fix;
   logic [QUO_W-1:0]   quo;
   logic signed [OUT_W-1:0] sval;
   logic signed [OUT_W-1:0] out_in;
   logic signed [OUT_W-1:0] out_ff;
   logic               accept;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;
   assign accept    = start & ~busy_ff;

   // configuration and control
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_scale_ff <= '0;
         gyro_scale_ff  <= '0;
         busy_ff        <= 1'b1;
         vld_ff         <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[NUM_STAGES-2:0], accept};
         if (csr_valid) begin
            case (csr_index)
               CSR_ACCEL_SCALE: accel_scale_ff <= csr_wdata;
               CSR_GYRO_SCALE:  gyro_scale_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // stage 1: sign and magnitude
   always_comb begin
      raw    = {req_raw_high, req_raw_low};
      mag_in = raw[RAW_W-1] ? MAG_W'(~raw + 16'd1) : raw;
      ctl_in = '{func: req_func, neg: raw[RAW_W-1],
                 accel_scale: accel_scale_ff, gyro_scale: gyro_scale_ff};
   end

   // stage 2: magnitude times the kind coefficient
   always_comb begin
      case (ctl_ff[0].func)
         FUNC_ACCEL: coef = ACCEL_COEF;
         FUNC_GYRO:  coef = GYRO_COEF;
         FUNC_TEMP:  coef = TEMP_COEF;
         default:    coef = '0;
      endcase
      prod_full = mag_ff * coef;
   end

   // stage 3: rounding offset and power-of-two shifts
   always_comb begin
      ash   = ACCEL_SHIFT_BASE - {2'b00, ctl_ff[1].accel_scale};
      gsh   = GYRO_SHIFT_BASE - {2'b00, ctl_ff[1].gyro_scale};
      ghalf = PROD_W'(1) << (gsh - 4'd1);
      case (ctl_ff[1].func)
         FUNC_ACCEL: num_in = NUM_W'(prod_ff >> ash) + ACCEL_HALF;
         FUNC_GYRO:  num_in = NUM_W'((prod_ff + ghalf) >> gsh);
         FUNC_TEMP:  num_in = NUM_W'(prod_ff) + TEMP_HALF;
         default:    num_in = '0;
      endcase
   end

   // stage 4: reciprocal multiply for the constant divisors
   always_comb begin
      case (ctl_ff[2].func)
         FUNC_ACCEL: rcp = ACCEL_RCP;
         FUNC_GYRO:  rcp = GYRO_RCP;
         FUNC_TEMP:  rcp = TEMP_RCP;
         default:    rcp = '0;
      endcase
      wide_in = num_ff * rcp;
   end

   // stage 5: quotient estimate, and back-multiply for the temperature check
   always_comb begin
      case (ctl_ff[3].func)
         FUNC_ACCEL: q0_in = QUO_W'(wide_ff >> ACCEL_RCP_SHIFT);
         FUNC_GYRO:  q0_in = wide_ff[QUO_W-1:0];
         FUNC_TEMP:  q0_in = QUO_W'(wide_ff >> TEMP_RCP_SHIFT);
         default:    q0_in = '0;
      endcase
      tq      = wide_ff[TEMP_RCP_SHIFT +: TQ_W];
      qd_full = tq * TEMP_DIV;
   end

   // stage 6: temperature estimate may be one short, then sign and offset
   always_comb begin
      rem  = num5_ff - qd_ff;
      fix  = (ctl_ff[4].func == FUNC_TEMP) && (rem >= NUM_W'(TEMP_DIV));
      quo  = q0_ff + QUO_W'(fix);
      sval = ctl_ff[4].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      case (ctl_ff[4].func)
         FUNC_ACCEL: out_in = sval;
         FUNC_GYRO:  out_in = sval;
         FUNC_TEMP:  out_in = sval + TEMP_OFFSET;
         default:    out_in = '0;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_in;
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
      mag_ff  <= mag_in;
      prod_ff <= prod_full[PROD_W-1:0];
      num_ff  <= num_in;
      wide_ff <= wide_in;
      num4_ff <= num_ff;
      q0_ff   <= q0_in;
      qd_ff   <= NUM_W'(qd_full);
      num5_ff <= num4_ff;
      out_ff  <= out_in;
   end

   assign rsp_valid        = vld_ff[NUM_STAGES-1];
   assign rsp_scaled_value = out_ff;

endmodule

### design/imu_rsu_checker.sv
// imu_rsu_checker: port-level assertions for imu_raw_sample_to_units,
// bound to the top level; uses imu_rsu_pkg
module imu_rsu_checker import imu_rsu_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [FUNC_W-1:0]       req_func,
   input logic [BYTE_W-1:0]       req_raw_high,
   input logic [BYTE_W-1:0]       req_raw_low,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_scaled_value
);

   // every accepted beat gives one result
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##6 rsp_valid)
      else $error("accepted beat gave no result");

   // no result without an earlier accepted beat
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without an accepted beat");

   // unused selector yields zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_UNUSED |-> ##6 rsp_scaled_value == '0)
      else $error("unused selector gave a nonzero value");

   // zero raw temperature is the bare offset
   a_temp_offset: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_TEMP && req_raw_high == '0 && req_raw_low == '0
      |-> ##6 rsp_scaled_value == TEMP_OFFSET)
      else $error("temperature offset wrong");

   // results stay inside the physical range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scaled_value >= OUT_MIN && rsp_scaled_value <= OUT_MAX)
      else $error("result out of range");

endmodule

bind imu_raw_sample_to_units imu_rsu_checker u_imu_rsu_checker (.*);

### bench/imu_raw_sample_to_units_test.sv
// imu_raw_sample_to_units_test: self-checking bench for the raw sample to units
// converter; drives commands and scale writes, checks every result beat
// depends on imu_rsu_pkg and imu_raw_sample_to_units
`timescale 1ns / 1ps

module imu_raw_sample_to_units_test;
   import imu_rsu_pkg::*;

   localparam int PIPE_LATENCY = NUM_STAGES;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;
   localparam int IDLE_PERCENT = 35;

   // unmapped register index, writes there must leave both scales alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;

   // conversion constants
   localparam longint G_MILLI      = 980665;   // standard gravity, 1e-5 m/s^2 units
   localparam longint ACCEL_SENS0  = 16384;    // counts per g at full-scale code 0
   localparam longint GYRO_MILLI   = 15625;
   localparam longint GYRO_DIV0    = 2048;
   localparam longint TEMP_MILLI   = 100000;
   localparam longint TEMP_SENS    = 33387;
   localparam longint TEMP_ZERO    = 21000;

   typedef enum logic [1:0] {OP_SAMPLE, OP_CSR_WRITE, OP_SETTLE} bench_op_kind_type;

   typedef struct {
      bench_op_kind_type       kind;
      logic [FUNC_W-1:0]       func;
      logic [BYTE_W-1:0]       raw_high;
      logic [BYTE_W-1:0]       raw_low;
      logic [CSR_IDX_W-1:0]    index;
      logic [SCALE_W-1:0]      wdata;
      bit                      no_gaps;
   } bench_op_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [BYTE_W-1:0]        req_raw_high = '0;
   logic [BYTE_W-1:0]        req_raw_low = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_scaled_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [SCALE_W-1:0]       csr_wdata = '0;

   bench_op_type             cmd_backlog[$];
   logic signed [OUT_W-1:0]  scaled_due[$];
   logic [SCALE_W-1:0]       accel_scale_q = '0;
   logic [SCALE_W-1:0]       gyro_scale_q = '0;
   bit                       stim_done = 1'b0;
   bit                       settling = 1'b0;
   int                       settle_count = 0;
   int                       mismatches = 0;
   int                       cycle_count = 0;

   imu_raw_sample_to_units dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_raw_high     (req_raw_high),
      .req_raw_low      (req_raw_low),
      .rsp_valid        (rsp_valid),
      .rsp_scaled_value (rsp_scaled_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // quotient rounded half away from zero on the magnitude
   function automatic longint div_half_away(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic signed [OUT_W-1:0] scale_sample(
      logic [FUNC_W-1:0] kind, logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
      logic [SCALE_W-1:0] a_scale, logic [SCALE_W-1:0] g_scale);
      logic signed [RAW_W-1:0] sample;
      longint raw;
      longint val;
      sample = {hi, lo};
      raw = sample;
      case (kind)
         FUNC_ACCEL: val = div_half_away(raw * G_MILLI, 100 * (ACCEL_SENS0 >> a_scale));
         FUNC_GYRO:  val = div_half_away(raw * GYRO_MILLI, GYRO_DIV0 >> g_scale);
         FUNC_TEMP:  val = div_half_away(raw * TEMP_MILLI, TEMP_SENS) + TEMP_ZERO;
         default:    val = 0;
      endcase
      return val[OUT_W-1:0];
   endfunction

   task automatic add_sample(logic [FUNC_W-1:0] kind, logic [RAW_W-1:0] raw, bit no_gaps);
      bench_op_type op;
      op = '{kind: OP_SAMPLE, func: kind, raw_high: raw[15:8], raw_low: raw[7:0],
             index: '0, wdata: '0, no_gaps: no_gaps};
      cmd_backlog.push_back(op);
   endtask

   task automatic add_settle();
      bench_op_type op;
      op = '{kind: OP_SETTLE, func: '0, raw_high: '0, raw_low: '0,
             index: '0, wdata: '0, no_gaps: 1'b0};
      cmd_backlog.push_back(op);
   endtask

   task automatic add_csr_write(logic [CSR_IDX_W-1:0] index, logic [SCALE_W-1:0] wdata);
      bench_op_type op;
      op = '{kind: OP_CSR_WRITE, func: '0, raw_high: '0, raw_low: '0,
             index: index, wdata: wdata, no_gaps: 1'b0};
      cmd_backlog.push_back(op);
   endtask

   // scale changes only once the pipe has drained
   task automatic set_scales(logic [SCALE_W-1:0] a_scale, logic [SCALE_W-1:0] g_scale);
      add_settle();
      add_csr_write(CSR_ACCEL_SCALE, a_scale);
      add_csr_write(CSR_SPARE, SCALE_W'($urandom_range(0, 3)));
      add_csr_write(CSR_GYRO_SCALE, g_scale);
   endtask

   function automatic logic [FUNC_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll < 5)
         return FUNC_ACCEL;
      else if (roll < 10)
         return FUNC_GYRO;
      else if (roll < 15)
         return FUNC_TEMP;
      return FUNC_UNUSED;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      logic [BYTE_W-1:0] corners[4];
      corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(0, 9) == 0)
         return corners[$urandom_range(0, 3)];
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   task automatic random_phase(logic [SCALE_W-1:0] a_scale, logic [SCALE_W-1:0] g_scale,
                               int count, bit no_gaps);
      set_scales(a_scale, g_scale);
      for (int i = 0; i < count; i++) begin
         // sender holds off mid-phase until every result is back
         if (i == count / 2)
            add_settle();
         add_sample(pick_kind(), {pick_byte(), pick_byte()}, no_gaps);
      end
   endtask

   // driver: one beat per command or register write
   always @(posedge clock) begin : drive
      bit           next_start;
      bit           next_csr;
      bench_op_type op;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         accel_scale_q <= '0;
         gyro_scale_q <= '0;
         settling = 1'b0;
      end else begin
         next_start = start;
         next_csr = csr_valid;
         if (start && !busy) begin
            scaled_due.push_back(scale_sample(req_func, req_raw_high, req_raw_low,
                                              accel_scale_q, gyro_scale_q));
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_SCALE: accel_scale_q <= csr_wdata;
               CSR_GYRO_SCALE:  gyro_scale_q <= csr_wdata;
               default: ;
            endcase
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr) begin
            if (settling) begin
               settle_count = (scaled_due.size() == 0) ? settle_count + 1 : 0;
               if (settle_count > PIPE_LATENCY)
                  settling = 1'b0;
            end else if (cmd_backlog.size() == 0) begin
               stim_done = 1'b1;
            end else if (cmd_backlog[0].no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT) begin
               op = cmd_backlog.pop_front();
               case (op.kind)
                  OP_SAMPLE: begin
                     next_start = 1'b1;
                     req_func <= op.func;
                     req_raw_high <= op.raw_high;
                     req_raw_low <= op.raw_low;
                  end
                  OP_CSR_WRITE: begin
                     next_csr = 1'b1;
                     csr_index <= op.index;
                     csr_wdata <= op.wdata;
                  end
                  default: begin
                     settling = 1'b1;
                     settle_count = 0;
                  end
               endcase
            end
         end
         start <= next_start;
         csr_valid <= next_csr;
      end
   end

   // monitor: every result beat against the oldest prediction
   always @(posedge clock) begin : watch
      logic signed [OUT_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (scaled_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: scaled_value %0d", rsp_scaled_value);
         end else begin
            want = scaled_due.pop_front();
            if (rsp_scaled_value !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("scaled_value mismatch: expected %0d, got %0d",
                           want, rsp_scaled_value);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("imu_raw_sample_to_units regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [RAW_W-1:0] corners[5];
      corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

      set_scales(2'd0, 2'd0);
      foreach (corners[i]) add_sample(FUNC_ACCEL, corners[i], 1'b0);
      foreach (corners[i]) add_sample(FUNC_GYRO, corners[i], 1'b0);
      foreach (corners[i]) add_sample(FUNC_TEMP, corners[i], 1'b0);
      add_sample(FUNC_UNUSED, 16'h1234, 1'b0);
      add_sample(FUNC_UNUSED, 16'hFFFF, 1'b0);
      set_scales(2'd3, 2'd3);
      add_sample(FUNC_ACCEL, 16'h7FFF, 1'b0);
      add_sample(FUNC_ACCEL, 16'h8000, 1'b0);
      add_sample(FUNC_GYRO, 16'h7FFF, 1'b0);
      add_sample(FUNC_GYRO, 16'h8000, 1'b0);
      // exact halves at the finest gyro divisor, both signs
      add_sample(FUNC_GYRO, 16'h0080, 1'b0);
      add_sample(FUNC_GYRO, 16'hFF80, 1'b0);

      random_phase(2'd1, 2'd2, 200, 1'b0);
      random_phase(2'd2, 2'd1, 200, 1'b0);
      random_phase(2'd0, 2'd3, 200, 1'b1);
      random_phase(2'd3, 2'd0, 200, 1'b0);
      random_phase(2'd3, 2'd3, 200, 1'b0);
      random_phase(2'd0, 2'd0, 200, 1'b0);
      random_phase(SCALE_W'($urandom_range(0, 3)), SCALE_W'($urandom_range(0, 3)),
                   200, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done && scaled_due.size() == 0);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (mismatches == 0 && scaled_due.size() == 0)
         $display("imu_raw_sample_to_units regression: pass");
      else
         $display("imu_raw_sample_to_units regression: fail");
      $finish;
   end

endmodule

### files.f
design/imu_rsu_pkg.sv
design/imu_raw_sample_to_units.sv
design/imu_rsu_checker.sv
bench/imu_raw_sample_to_units_test.sv
